// File: hdl/tprs_pkg.sv
// Shared command and status types for the timer prescale/reload search unit.
`timescale 1ns / 1ps
`default_nettype none
package tprs_pkg;

	// Controller to datapath strobes
	typedef struct packed {
		logic load;       // capture input beat, start cycles / reload_limit
		logic div_start;  // start a division
		logic set_mind;   // latch least divider, switch divisor to search divider
		logic direct;     // no prescale: reload is cycles clamped to reload_limit
		logic eval;       // score current divider, step to the next one
		logic publish;    // move best candidate into the output registers
	} tprs_cmd_t;

	// Datapath to controller flags
	typedef struct packed {
		logic div_done;   // quotient and remainder valid
		logic mind_le1;   // least divider is 0 or 1
		logic exact;      // current divider leaves no remainder
		logic last;       // no divider left below prescale_limit
	} tprs_sts_t;

endpackage
`default_nettype wire

// File: hdl/tprs_div.sv
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module tprs_div #(
	parameter int CYCLE_WIDTH = 64
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   start,
	input  wire logic [CYCLE_WIDTH-1:0] dividend,
	input  wire logic [CYCLE_WIDTH-1:0] divisor,   // held stable while busy
	output logic      [CYCLE_WIDTH-1:0] quot,
	output logic      [CYCLE_WIDTH-1:0] rem,
	output logic                        done
);
	localparam int CNT_W = $clog2(CYCLE_WIDTH);

	logic [CYCLE_WIDTH-1:0] quot_q;
	logic [CYCLE_WIDTH-1:0] rem_q;
	logic [CNT_W-1:0]       cnt_q;
	logic                   busy_q;
	logic                   done_q;
	logic [CYCLE_WIDTH:0]   partial;
	logic [CYCLE_WIDTH:0]   diff;
	logic                   ge;

	assign partial = {rem_q, quot_q[CYCLE_WIDTH-1]};
	assign diff    = partial - {1'b0, divisor};
	assign ge      = partial >= {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(CYCLE_WIDTH - 1);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quot_q <= dividend;
			rem_q  <= '0;
		end else if (busy_q) begin
			quot_q <= {quot_q[CYCLE_WIDTH-2:0], ge};
			rem_q  <= ge ? diff[CYCLE_WIDTH-1:0] : partial[CYCLE_WIDTH-1:0];
		end
	end

	assign quot = quot_q;
	assign rem  = rem_q;
	assign done = done_q;

endmodule
`default_nettype wire

// File: hdl/tprs_dp.sv
// Datapath: operand and candidate registers, rounding, scoring and result registers.
`timescale 1ns / 1ps
`default_nettype none
module tprs_dp #(
	parameter int CYCLE_WIDTH    = 64,
	parameter int PRESCALE_WIDTH = 16
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire tprs_pkg::tprs_cmd_t       cmd,
	output tprs_pkg::tprs_sts_t            sts,
	input  wire logic [CYCLE_WIDTH-1:0]    period_cycles,
	input  wire logic [PRESCALE_WIDTH-1:0] prescale_limit,
	input  wire logic [CYCLE_WIDTH-1:0]    reload_limit,
	output logic      [PRESCALE_WIDTH-1:0] prescale_code,
	output logic      [CYCLE_WIDTH-1:0]    reload_value,
	output logic                           status
);
	import tprs_pkg::*;

	localparam logic [PRESCALE_WIDTH-1:0] PRE_MAX = '1;

	logic [CYCLE_WIDTH-1:0]    cyc_q;
	logic [CYCLE_WIDTH-1:0]    rl_q;
	logic [PRESCALE_WIDTH-1:0] pl_q;
	logic [PRESCALE_WIDTH-1:0] d_q;
	logic                      search_q;
	logic                      found_q;
	logic [PRESCALE_WIDTH-1:0] best_d_q;
	logic [CYCLE_WIDTH-1:0]    best_r_q;
	logic [CYCLE_WIDTH-1:0]    best_err_q;
	logic [PRESCALE_WIDTH-1:0] code_q;
	logic [CYCLE_WIDTH-1:0]    reload_q;
	logic                      status_q;

	logic [CYCLE_WIDTH-1:0]    dividend;
	logic [CYCLE_WIDTH-1:0]    divisor;
	logic [CYCLE_WIDTH-1:0]    quot;
	logic [CYCLE_WIDTH-1:0]    rem;
	logic                      div_done;
	logic [CYCLE_WIDTH-1:0]    gap;
	logic                      round_up;
	logic [CYCLE_WIDTH-1:0]    err;
	logic [CYCLE_WIDTH-1:0]    q_round;
	logic [PRESCALE_WIDTH-1:0] mind_raw;
	logic [PRESCALE_WIDTH-1:0] mind;
	logic [CYCLE_WIDTH-1:0]    direct_r;
	logic [PRESCALE_WIDTH:0]   d_next;

	assign dividend = cmd.load ? period_cycles : cyc_q;
	assign divisor  = search_q ? CYCLE_WIDTH'(d_q) : rl_q;

	tprs_div #(
		.CYCLE_WIDTH(CYCLE_WIDTH)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.div_start),
		.dividend(dividend),
		.divisor (divisor),
		.quot    (quot),
		.rem     (rem),
		.done    (div_done)
	);

	// halves round up; error is distance to the nearer multiple
	assign gap      = divisor - rem;
	assign round_up = rem >= gap;
	assign err      = round_up ? gap : rem;
	assign q_round  = quot + CYCLE_WIDTH'(round_up);

	always_comb begin
		if (rl_q == '0 || q_round >= CYCLE_WIDTH'(PRE_MAX))
			mind_raw = PRE_MAX;
		else
			mind_raw = q_round[PRESCALE_WIDTH-1:0] + 1'b1;
		mind = (mind_raw > pl_q) ? pl_q : mind_raw;
	end

	assign direct_r = (cyc_q > rl_q) ? rl_q : cyc_q;
	assign d_next   = {1'b0, d_q} + 1'b1;

	assign sts.div_done = div_done;
	assign sts.mind_le1 = mind <= PRESCALE_WIDTH'(1);
	assign sts.exact    = rem == '0;
	assign sts.last     = d_next >= {1'b0, pl_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			search_q <= 1'b0;
			found_q  <= 1'b0;
		end else if (cmd.load) begin
			search_q <= 1'b0;
			found_q  <= 1'b0;
		end else begin
			if (cmd.set_mind)
				search_q <= 1'b1;
			if (cmd.direct)
				found_q <= 1'b1;
			if (cmd.eval && (rem == '0 || d_q < pl_q))
				found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cyc_q <= period_cycles;
			rl_q  <= reload_limit;
			pl_q  <= prescale_limit;
		end
		if (cmd.set_mind)
			d_q <= mind;
		if (cmd.direct) begin
			best_d_q   <= PRESCALE_WIDTH'(1);
			best_r_q   <= direct_r;
			best_err_q <= cyc_q - direct_r;
		end
		if (cmd.eval) begin
			d_q <= d_next[PRESCALE_WIDTH-1:0];
			if (rem == '0) begin
				best_d_q   <= d_q;
				best_r_q   <= quot;
				best_err_q <= '0;
			end else if (d_q < pl_q && (!found_q || err < best_err_q)) begin
				best_d_q   <= d_q;
				best_r_q   <= q_round;
				best_err_q <= err;
			end
		end
		if (cmd.publish) begin
			code_q   <= found_q ? best_d_q - 1'b1 : '0;
			reload_q <= found_q ? best_r_q : '0;
			status_q <= found_q ? (best_err_q > CYCLE_WIDTH'(1)) : 1'b1;
		end
	end

	assign prescale_code = code_q;
	assign reload_value  = reload_q;
	assign status        = status_q;

endmodule
`default_nettype wire

// File: hdl/tprs_ctrl.sv
// Controller: sequences the divisions of one request and owns the output valid.
`timescale 1ns / 1ps
`default_nettype none
module tprs_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output tprs_pkg::tprs_cmd_t      cmd,
	input  wire tprs_pkg::tprs_sts_t sts
);
	import tprs_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DIV1,
		S_MIND,
		S_DIV2,
		S_EVAL,
		S_DONE
	} state_t;

	state_t state_q;
	state_t state_nxt;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load      = 1'b1;
					cmd.div_start = 1'b1;
					state_nxt     = S_DIV1;
				end
			end
			S_DIV1: begin
				if (sts.div_done)
					state_nxt = S_MIND;
			end
			S_MIND: begin
				if (sts.mind_le1) begin
					cmd.direct = 1'b1;
					state_nxt  = S_DONE;
				end else begin
					cmd.set_mind  = 1'b1;
					cmd.div_start = 1'b1;
					state_nxt     = S_DIV2;
				end
			end
			S_DIV2: begin
				if (sts.div_done)
					state_nxt = S_EVAL;
			end
			S_EVAL: begin
				cmd.eval = 1'b1;
				if (sts.exact || sts.last) begin
					state_nxt = S_DONE;
				end else begin
					cmd.div_start = 1'b1;
					state_nxt     = S_DIV2;
				end
			end
			S_DONE: begin
				if (out_free) begin
					cmd.publish = 1'b1;
					state_nxt   = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.publish)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	assign in_stall  = state_q != S_IDLE;
	assign out_valid = out_valid_q;

endmodule
`default_nettype wire

// File: hdl/timer_prescale_reload_search_unit.sv
// Top level of the timer prescale/reload search unit.
// Usage:
//   Input channel (in_valid / in_stall) takes one beat of period_cycles,
//   prescale_limit and reload_limit. in_stall is high while a request is in
//   work; only one request is handled at a time.
//   Output channel (out_valid / out_stall) returns prescale_code,
//   reload_value and status for each request, in order. The result sits in
//   an output register, so a new request is taken while the previous result
//   is still waiting; finished work holds until that register frees up.
// Operation:
//   All work runs on one radix-2 divider, one quotient bit per cycle.
//   With no prescale one division serves; otherwise one more division
//   runs for each divider tried (1 up to 2^PRESCALE_WIDTH - 3). The next
//   request is taken the cycle after the result is written.
// Reset (arst_n low) empties the unit: no result valid, input open.
// A stalled result holds its value until accepted.
`timescale 1ns / 1ps
`default_nettype none
module timer_prescale_reload_search_unit #(
	parameter int CYCLE_WIDTH    = 64,
	parameter int PRESCALE_WIDTH = 16
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	output logic                           in_stall,
	input  wire logic [CYCLE_WIDTH-1:0]    period_cycles,
	input  wire logic [PRESCALE_WIDTH-1:0] prescale_limit,
	input  wire logic [CYCLE_WIDTH-1:0]    reload_limit,
	output logic                           out_valid,
	input  wire logic                      out_stall,
	output logic      [PRESCALE_WIDTH-1:0] prescale_code,
	output logic      [CYCLE_WIDTH-1:0]    reload_value,
	output logic                           status
);
	import tprs_pkg::*;

	tprs_cmd_t cmd;
	tprs_sts_t sts;

	tprs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.cmd      (cmd),
		.sts      (sts)
	);

	tprs_dp #(
		.CYCLE_WIDTH   (CYCLE_WIDTH),
		.PRESCALE_WIDTH(PRESCALE_WIDTH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.period_cycles (period_cycles),
		.prescale_limit(prescale_limit),
		.reload_limit  (reload_limit),
		.prescale_code (prescale_code),
		.reload_value  (reload_value),
		.status        (status)
	);

endmodule
`default_nettype wire

// File: bench/tb_timer_prescale_reload_search_unit.sv
// Self-checking bench for the timer prescale/reload search unit.
`timescale 1ns / 1ps
module tb_timer_prescale_reload_search_unit;

	localparam int CW = 64;
	localparam int PW = 16;
	localparam logic [CW-1:0] PRE_MAX = (64'd1 << PW) - 64'd1;
	localparam logic [CW-1:0] ALL_ONES = {CW{1'b1}};
	localparam int RANDOM_ITEMS = 81;
	localparam int MAX_SEARCH = 64;   // cap on dividers tried per random request
	localparam int HOLD_AT = 20;      // result count that starts the long hold-off
	localparam int HOLD_CYCLES = 3000;

	typedef struct {
		logic [PW-1:0] code;
		logic [CW-1:0] reload;
		logic          fail;
	} split_t;

	typedef struct {
		logic [CW-1:0] cycles;
		logic [PW-1:0] plimit;
		logic [CW-1:0] rlimit;
		int unsigned   gap;
		logic          drain;   // hold this one back until all results are in
	} request_t;

	logic clk;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic [CW-1:0] period_cycles = '0;
	logic [PW-1:0] prescale_limit = '0;
	logic [CW-1:0] reload_limit = '0;
	logic out_stall = 1'b0;
	logic in_stall;
	logic out_valid;
	logic [PW-1:0] prescale_code;
	logic [CW-1:0] reload_value;
	logic status;

	request_t request_q[$];
	split_t pending_splits[$];
	int unsigned mismatches = 0;
	int unsigned results_seen = 0;
	int unsigned send_wait = 0;
	int unsigned recv_wait = 0;
	int unsigned hold_left = 0;
	longint unsigned cycle_budget = 0;
	longint unsigned cycle_count = 0;
	int unsigned item_idx = 0;
	split_t split_now;
	split_t want;
	int unsigned tries_now;

	timer_prescale_reload_search_unit #(
		.CYCLE_WIDTH(CW),
		.PRESCALE_WIDTH(PW)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.period_cycles(period_cycles),
		.prescale_limit(prescale_limit),
		.reload_limit(reload_limit),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.prescale_code(prescale_code),
		.reload_value(reload_value),
		.status(status)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// quotient rounded half up, err = |q*d - n|
	function automatic logic [CW-1:0] round_quot(input logic [CW-1:0] n,
			input logic [CW-1:0] d, output logic [CW-1:0] err);
		logic [CW-1:0] q;
		logic [CW-1:0] rem;
		q = n / d;
		rem = n % d;
		if (rem >= d - rem) begin
			err = d - rem;
			return q + 1;
		end
		err = rem;
		return q;
	endfunction

	function automatic void predict_split(input logic [CW-1:0] cyc, input logic [PW-1:0] plim,
			input logic [CW-1:0] rlim, output split_t res, output int unsigned tries);
		logic [CW-1:0] q;
		logic [CW-1:0] e;
		logic [CW-1:0] rel;
		logic [CW-1:0] mind;
		logic [CW-1:0] d;
		logic [CW-1:0] best_e;
		logic [CW-1:0] best_r;
		logic [CW-1:0] best_d;
		logic found;
		tries = 0;
		if (rlim == 0) begin
			mind = PRE_MAX;
		end else begin
			q = round_quot(cyc, rlim, e);
			mind = (q >= PRE_MAX) ? PRE_MAX : q + 1;
		end
		if (mind > plim)
			mind = plim;
		if (mind <= 1) begin
			res.reload = (cyc > rlim) ? rlim : cyc;
			res.code = '0;
			res.fail = (cyc - res.reload) > 1;
		end else if (cyc % mind == 0) begin
			tries = 1;
			res.code = PW'(mind - 1);
			res.reload = cyc / mind;
			res.fail = 1'b0;
		end else begin
			found = 1'b0;
			best_e = '0;
			best_r = '0;
			best_d = '0;
			for (d = mind; d < plim; d++) begin
				tries++;
				rel = round_quot(cyc, d, e);
				if (!found || e < best_e) begin
					found = 1'b1;
					best_e = e;
					best_d = d;
					best_r = rel;
				end
				if (e == 0)
					break;
			end
			if (found) begin
				res.code = PW'(best_d - 1);
				res.reload = best_r;
				res.fail = best_e > 1;
			end else begin
				res.code = '0;
				res.reload = '0;
				res.fail = 1'b1;
			end
		end
	endfunction

	function automatic logic [CW-1:0] rand64();
		return {$urandom, $urandom};
	endfunction

	task automatic add_request(input logic [CW-1:0] cyc, input logic [PW-1:0] plim,
			input logic [CW-1:0] rlim, input logic drain);
		request_t r;
		split_t s;
		int unsigned n;
		predict_split(cyc, plim, rlim, s, n);
		r.cycles = cyc;
		r.plimit = plim;
		r.rlimit = rlim;
		r.drain = drain;
		// bursts with no idling every 32 requests
		r.gap = (item_idx % 32 < 8) ? 0 : $urandom_range(0, 13);
		item_idx++;
		request_q.push_back(r);
		cycle_budget += 120 + 65 * (n + 2) + 2 * 14;
	endtask

	task automatic add_random(input logic drain);
		logic [CW-1:0] c;
		logic [CW-1:0] r;
		logic [CW-1:0] qq;
		logic [CW-1:0] dv;
		logic [PW-1:0] p;
		split_t s;
		int unsigned n;
		int unsigned span;
		int unsigned attempt;
		for (attempt = 0; attempt < 40; attempt++) begin
			case ($urandom_range(0, 3))
				0: begin
					// small limits, operands of any size
					p = $urandom_range(0, 64);
					c = rand64() >> $urandom_range(0, 63);
					r = rand64() >> $urandom_range(0, 63);
				end
				1: begin
					// least divider lands just below the limit
					p = $urandom_range(2, 65535);
					span = (p - 2 < 30) ? p - 2 : 30;
					qq = p - 1 - $urandom_range(0, span);
					r = rand64() >> $urandom_range(16, 63);
					if (r == 0)
						r = 1;
					c = r * qq + rand64() % r;
				end
				2: begin
					// saturated divider
					p = ($urandom_range(0, 3) == 0) ? 16'hffff : 16'($urandom);
					r = $urandom_range(1, 1000);
					c = rand64() | (64'd1 << 63);
				end
				default: begin
					// exact factor near the least divider
					p = $urandom_range(2, 65535);
					dv = $urandom_range(2, p);
					r = rand64() >> $urandom_range(17, 63);
					if (r == 0)
						r = 1;
					c = dv * r;
					r = c / (dv - 1);
				end
			endcase
			if (r == 0)
				r = 1;
			predict_split(c, p, r, s, n);
			if (n <= MAX_SEARCH)
				break;
		end
		if (n > MAX_SEARCH) begin
			p = $urandom_range(0, 64);
			c = rand64();
			r = rand64() >> $urandom_range(0, 63);
			if (r == 0)
				r = 1;
		end
		add_request(c, p, r, drain);
	endtask

	// sender
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			send_wait = 0;
		end else begin
			if (in_valid && !in_stall) begin
				predict_split(period_cycles, prescale_limit, reload_limit, split_now, tries_now);
				pending_splits.push_back(split_now);
			end
			if (!in_valid || !in_stall) begin
				if (send_wait != 0) begin
					in_valid <= 1'b0;
					send_wait--;
				end else if (request_q.size() != 0 &&
						!(request_q[0].drain && pending_splits.size() != 0)) begin
					in_valid <= 1'b1;
					period_cycles <= request_q[0].cycles;
					prescale_limit <= request_q[0].plimit;
					reload_limit <= request_q[0].rlimit;
					send_wait = request_q[0].gap;
					request_q.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver and checker
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			recv_wait = 0;
			hold_left = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (pending_splits.size() == 0) begin
					$error("result beat with nothing expected: code %0d reload %0d status %0d",
						prescale_code, reload_value, status);
					mismatches++;
				end else begin
					want = pending_splits.pop_front();
					if (prescale_code !== want.code) begin
						$error("prescale_code: expected %0d, got %0d", want.code, prescale_code);
						mismatches++;
					end
					if (reload_value !== want.reload) begin
						$error("reload_value: expected %0d, got %0d", want.reload, reload_value);
						mismatches++;
					end
					if (status !== want.fail) begin
						$error("status: expected %0d, got %0d", want.fail, status);
						mismatches++;
					end
				end
				results_seen++;
				recv_wait = (results_seen % 32 < 8) ? 0 : $urandom_range(0, 13);
				if (results_seen == HOLD_AT)
					hold_left = HOLD_CYCLES;
			end else if (recv_wait != 0) begin
				recv_wait--;
			end
			if (hold_left != 0)
				hold_left--;
			out_stall <= (recv_wait != 0) || (hold_left != 0);
		end
	end

	initial begin
		// zero everywhere, prescale limit zero collapses to no prescale
		add_request(64'd0, 16'd0, 64'd0, 1'b0);
		// all ones; 3 divides 2^64-1
		add_request(ALL_ONES, 16'hffff, ALL_ONES, 1'b0);
		// no prescaler, reload clamped far off
		add_request(ALL_ONES, 16'd0, 64'd1, 1'b0);
		// reload limit zero, empty search
		add_request(64'd5, 16'd100, 64'd0, 1'b0);
		// saturated divider, empty search
		add_request(64'd1 << 40, 16'hffff, 64'd1, 1'b0);
		// saturated divider that divides exactly
		add_request(ALL_ONES, 16'hffff, 64'd1, 1'b0);
		// least divider divides exactly
		add_request(64'd1000, 16'd10, 64'd300, 1'b0);
		// search ends on an exact match
		add_request(64'd1001, 16'd20, 64'd300, 1'b0);
		// search keeps an error above one, so status flags a failure
		add_request(64'd10007, 16'd8, 64'd1668, 1'b0);
		// ties keep the first divider
		add_request(64'd22, 16'd8, 64'd10, 1'b0);
		// direct reload, off by one, off by more and exact
		add_request(64'd100, 16'd1, 64'd99, 1'b0);
		add_request(64'd100, 16'd1, 64'd50, 1'b0);
		add_request(64'd7, 16'hffff, 64'd1000, 1'b0);
		// least divider clamped to the limit
		add_request(64'd9, 16'd2, 64'd1, 1'b0);
		add_request(64'd9, 16'd3, 64'd1, 1'b0);
		// half rounds up, then wide operands
		add_request(64'd15, 16'd3, 64'd10, 1'b0);
		add_request(64'd1 << 63, 16'h8000, 64'd1 << 48, 1'b0);
		add_request(ALL_ONES, 16'h7fff, ALL_ONES >> 1, 1'b0);
		add_request(ALL_ONES >> 1, 16'h5555, 64'hffff_0000_0000_0000, 1'b0);
		for (int i = 0; i < RANDOM_ITEMS; i++)
			add_random(i == 0 || i == RANDOM_ITEMS / 2);
		cycle_budget += HOLD_CYCLES + 2000;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		while (request_q.size() != 0 || in_valid || pending_splits.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	// watchdog
	initial begin
		@(posedge arst_n);
		while (cycle_count < 4 * cycle_budget + 20000) begin
			@(posedge clk);
			cycle_count++;
		end
		$error("timeout with %0d requests unsent and %0d results outstanding",
			request_q.size(), pending_splits.size());
		$display("TEST FAILED");
		$finish;
	end

endmodule
